// ----- rtl/wildcard_pattern_match_macros.svh -----
// Assertion macros for the wildcard pattern matcher.
`ifndef WILDCARD_PATTERN_MATCH_MACROS_SVH
`define WILDCARD_PATTERN_MATCH_MACROS_SVH

`ifndef SYNTH
`define WPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpm check failed");
`define WPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpm check failed");
`else
`define WPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define WPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/wpm_pkg.sv -----
// Shared constants and types of the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

  localparam int MAX_PAT = 64;
  localparam int LEN_W   = $clog2(MAX_PAT + 1);

  localparam logic [7:0] STAR_CODE  = 8'd42;
  localparam logic [7:0] QMARK_CODE = 8'd63;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Wavefront of one text character travelling along the cells.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic [7:0] c;
    logic       m_prev;
    logic       n_prev;
    logic       res;
  } wave_t;

  // Pattern load controls for one cell.
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       wr;
    logic [7:0] ch;
    logic       e;
  } pat_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/wpm_cell.sv -----
// One pattern position: stored character, empty-text bit and match bit.
`default_nettype none

module wpm_cell (
  input  wire               clk,
  input  wire               rst,
  input  wpm_pkg::pat_ctl_t ctl,
  input  wpm_pkg::wave_t    wave_in,
  output wpm_pkg::wave_t    wave_out
);

  logic       used;
  logic [7:0] pch;
  logic       e;
  logic       m;
  logic       m_old;
  logic       nw;

  always_comb begin
    m_old = wave_in.first ? e : m;
    if ((pch == wave_in.c) || (pch == wpm_pkg::QMARK_CODE)) begin
      nw = wave_in.m_prev;
    end else if (pch == wpm_pkg::STAR_CODE) begin
      nw = m_old | wave_in.n_prev;
    end else begin
      nw = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.wr) begin
      used <= 1'b1;
    end else if (ctl.clear) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      pch <= ctl.ch;
      e   <= ctl.e;
    end
    if (ctl.load) begin
      m <= ctl.wr ? ctl.e : e;
    end else if (wave_in.valid) begin
      m <= nw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
    end
    wave_out.first  <= wave_in.first;
    wave_out.c      <= wave_in.c;
    wave_out.m_prev <= m_old;
    wave_out.n_prev <= used ? nw : 1'b0;
    wave_out.res    <= used ? nw : wave_in.res;
  end

endmodule

`default_nettype wire

// ----- rtl/wildcard_pattern_match.sv -----
// Top level of the wildcard pattern matcher: control and a chain of match cells.
// Pattern item: result the cycle after acceptance; next item may follow at once if
// m_tready. Text item: the character sweeps the MAX_PAT cells one per cycle, and
// its result is registered off the last cell; one text item is in flight at a time.
// Reset empties the pattern, clears overflow and leaves the empty text matched.
`default_nettype none
`include "wildcard_pattern_match_macros.svh"

module wildcard_pattern_match (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,  // [7:0] char_code, [8] first
  input  wire         s_tuser,  // [0] kind
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata   // [0] matched, [1] overflow
);

  localparam int N = wpm_pkg::MAX_PAT;
  localparam int W = wpm_pkg::LEN_W;

  wpm_pkg::state_t state;
  wpm_pkg::state_t state_next;

  logic [W-1:0] pat_len;
  logic         all_star;
  logic         ovf;
  logic         m0;
  logic         out_matched;
  logic         out_ovf;

  logic         acc;
  logic         acc_pat;
  logic         acc_text;
  logic         first;
  logic [7:0]   ch;
  logic [W-1:0] eff_len;
  logic         eff_star;
  logic         eff_ovf;
  logic         full;
  logic         star_new;
  logic         ovf_new;

  wpm_pkg::wave_t    waves [0:N];
  wpm_pkg::pat_ctl_t ctls  [0:N-1];

  assign ch       = s_tdata[7:0];
  assign first    = s_tdata[8];
  assign acc      = s_tvalid & s_tready;
  assign acc_pat  = acc & (s_tuser == wpm_pkg::KIND_PATTERN);
  assign acc_text = acc & (s_tuser == wpm_pkg::KIND_TEXT);

  assign eff_len  = first ? '0 : pat_len;
  assign eff_star = first | all_star;
  assign eff_ovf  = ~first & ovf;
  assign full     = (eff_len == W'(N));
  assign star_new = full ? eff_star : (eff_star & (ch == wpm_pkg::STAR_CODE));
  assign ovf_new  = eff_ovf | full;

  always_comb begin
    waves[0].valid  = acc_text;
    waves[0].first  = first;
    waves[0].c      = ch;
    waves[0].m_prev = first | m0;
    waves[0].n_prev = 1'b0;
    waves[0].res    = 1'b0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      ctls[i].clear = acc_pat & first;
      ctls[i].load  = acc_pat;
      ctls[i].wr    = acc_pat & ~full & (eff_len == W'(i));
      ctls[i].ch    = ch;
      ctls[i].e     = eff_star & (ch == wpm_pkg::STAR_CODE);
    end

    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctls[i]),
      .wave_in  (waves[i]),
      .wave_out (waves[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wpm_pkg::ST_IDLE: begin
        if (acc_text) begin
          state_next = wpm_pkg::ST_BUSY;
        end
      end
      wpm_pkg::ST_BUSY: begin
        if (waves[N].valid) begin
          state_next = wpm_pkg::ST_IDLE;
        end
      end
      default: state_next = wpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      wpm_pkg::ST_IDLE: s_tready = ~m_tvalid | m_tready;
      wpm_pkg::ST_BUSY: s_tready = 1'b0;
      default:          s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wpm_pkg::ST_IDLE;
      pat_len  <= '0;
      all_star <= 1'b1;
      ovf      <= 1'b0;
      m0       <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_pat) begin
        pat_len  <= full ? eff_len : eff_len + W'(1);
        all_star <= star_new;
        ovf      <= ovf_new;
        m0       <= 1'b1;
      end else if (acc_text) begin
        m0 <= 1'b0;
      end
      if (acc_pat || waves[N].valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pat) begin
      out_matched <= star_new;
      out_ovf     <= ovf_new;
    end else if (waves[N].valid) begin
      out_matched <= waves[N].res;
      out_ovf     <= ovf;
    end
  end

  assign m_tdata = {6'd0, out_ovf, out_matched};

  `WPM_ASSERT_NEXT(a_text_busy, clk, rst, acc_text, state == wpm_pkg::ST_BUSY)
  `WPM_ASSERT_IMPLY(a_busy_stall, clk, rst, state == wpm_pkg::ST_BUSY, !s_tready)
  `WPM_ASSERT_IMPLY(a_tail_busy, clk, rst, waves[N].valid, state == wpm_pkg::ST_BUSY)
  `WPM_ASSERT_IMPLY(a_ovf_full, clk, rst, ovf, pat_len == W'(N))
  `WPM_ASSERT_IMPLY(a_empty_star, clk, rst, pat_len == '0, all_star)

endmodule

`default_nettype wire
